### rtl/ipv6p_pkg.sv
// Shared types and constants for the IPv6 address text parser.
// Used by the front end, the item queue and the parse back end.
package ipv6p_pkg;

  // ASCII codes of the characters the parser recognizes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Address geometry and parse limits
  localparam int GROUP_W = 16;
  localparam int ADDR_W  = 128;
  localparam logic [3:0] NGROUPS    = 4'd8;
  localparam logic [3:0] NO_GAP     = 4'd8;
  localparam logic [2:0] MAX_DIGITS = 3'd4;
  localparam logic [1:0] GAP_COLONS = 2'd2;

  // Default depth of the queue between front and back end
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified character
  typedef struct packed {
    logic       end_txt;   // end marker, character ignored
    logic       is_hex;    // hex digit
    logic       is_colon;  // colon character
    logic [3:0] hex_val;   // digit value when is_hex
  } cls_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cls_t item;
  } queue_out_t;

endpackage

### rtl/ipv6_address_text_parser_core.sv
// IPv6 address text parser, top level.
// Depends on ipv6p_pkg, ipv6p_front, ipv6p_queue and ipv6p_back.
//
// Usage:
//   The input stream carries one ASCII character per item in s_tdata; s_tlast
//   marks the end of the text (its character is ignored). Hex digits, colons
//   and '::' are collected; any other character or the end marker closes the
//   address and yields one result item. A malformed address (too many groups,
//   a fifth digit, a second '::') yields a failure result at once, and the
//   rest of the text up to and including the next terminator is dropped.
//   The result stream gives the address in m_tdata and the flags parse_ok
//   and char_returned in m_tuser; a failure carries an all-zero address.
//   Throughput: one character per cycle, sustained while the result side does
//   not stall; the front end classifies in the accept cycle.
//   A result is registered at the same edge its character leaves the queue;
//   the character passes through a queue entry, then the result sits in the
//   output register that drives m_tvalid.
//   Reset (rst, synchronous) empties the queue, drops any pending result and
//   clears the parse state. While a result waits with m_tready low, it holds,
//   the back end stops popping, and s_tready falls once the queue is full.
module ipv6_address_text_parser_core import ipv6p_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] character
  input  logic              s_tlast,   // end_of_text
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [ADDR_W-1:0] m_tdata,   // [63:0] address_high, [127:64] address_low
  output logic [1:0]        m_tuser    // [0] parse_ok, [1] char_returned
);

  logic       q_full;
  logic       push;
  cls_t       push_item;
  logic       pop;
  queue_out_t q_head;

  ipv6p_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ipv6p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .head      (q_head)
  );

  ipv6p_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A failure result never carries address bits
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("failure result carries a nonzero address");

  // A new result needs an item at the queue head in the cycle before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_head.valid))
    else $error("result appeared without a queued item");

  // Leaving reset, the queue is empty and no result is pending
  a_reset_clean: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready && !m_tvalid && !q_head.valid)
    else $error("state not cleared by reset");

endmodule

### rtl/ipv6p_front.sv
// Front end: accepts characters from the input stream and classifies them.
// Depends on ipv6p_pkg; pushes classified items into ipv6p_queue.
module ipv6p_front import ipv6p_pkg::*; (
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // character
  input  logic       s_tlast,   // end_of_text
  input  logic       q_full,
  output logic       push,
  output cls_t       push_item
);

  // Decode one ASCII character into digit / colon flags
  function automatic cls_t classify(input logic [7:0] c, input logic last);
    cls_t r;
    r.end_txt  = last;
    r.is_hex   = 1'b0;
    r.hex_val  = 4'd0;
    r.is_colon = (c == CH_COLON);
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - CH_ZERO);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - CH_LA + 8'd10);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - CH_UA + 8'd10);
    end
    return r;
  endfunction

  // Accept whenever the queue has room
  assign s_tready  = !q_full;
  assign push      = s_tvalid && !q_full;
  assign push_item = classify(s_tdata, s_tlast);

endmodule

### rtl/ipv6p_queue.sv
// Small FIFO of classified items between front and back end.
// Depends on ipv6p_pkg for the item type.
module ipv6p_queue import ipv6p_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cls_t       push_item,
  input  logic       pop,
  output logic       full,
  output queue_out_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/ipv6p_back.sv
// Back end: runs the parse state on classified items, expands '::' and
// registers one result per finished address. Depends on ipv6p_pkg.
module ipv6p_back import ipv6p_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  queue_out_t         head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [ADDR_W-1:0]  m_tdata,  // address_high, address_low
  output logic [1:0]         m_tuser   // parse_ok, char_returned
);

  // Parse state
  logic [GROUP_W-1:0] cur, cur_next;
  logic [2:0]         dcnt, dcnt_next;
  logic [1:0]         ccnt, ccnt_next;
  logic [3:0]         gcnt, gcnt_next;
  logic [3:0]         gap, gap_next;
  logic               skip, skip_next;
  logic [ADDR_W-1:0]  tail, tail_next;
  logic [GROUP_W-1:0] head_grp [8];

  // Group writes before the gap
  logic               head_we;
  logic [2:0]         head_idx;
  logic [GROUP_W-1:0] head_data;

  // Output register
  logic              out_valid;
  logic              out_ok;
  logic              out_ret;
  logic [ADDR_W-1:0] out_addr;

  // Result of this step
  logic              res_fire;
  logic              res_ok;
  logic              res_ret;
  logic [ADDR_W-1:0] res_addr;

  // Finish path signals
  logic               store_cur;
  logic               has_gap;
  logic [3:0]         n_fin;
  logic               ok_fin;
  logic [ADDR_W-1:0]  tail_fin;
  logic [ADDR_W-1:0]  head_flat;
  logic [ADDR_W-1:0]  addr_fin;

  // Step temporaries
  logic               iscol;
  logic               fail;
  logic               clear;
  logic [1:0]         c1;
  logic [2:0]         d1;
  logic [GROUP_W-1:0] cur1;
  logic [3:0]         gap1;

  assign pop = head.valid && (!out_valid || m_tready);

  // Expand '::': head groups before the gap, zeros, then tail groups
  always_comb begin
    logic [GROUP_W-1:0] g;
    has_gap   = (gap != NO_GAP);
    store_cur = (dcnt != 3'd0) && (gcnt < NGROUPS);
    n_fin     = gcnt + {3'd0, store_cur};
    ok_fin    = has_gap || (n_fin == NGROUPS);
    tail_fin  = (store_cur && has_gap) ? {tail[ADDR_W-GROUP_W-1:0], cur} : tail;
    head_flat = '0;
    for (int i = 0; i < 8; i++) begin
      g = head_grp[i];
      if (store_cur && !has_gap && (gcnt[2:0] == 3'(i))) begin
        g = cur;
      end
      if (has_gap && !(4'(i) < gap)) begin
        g = '0;
      end
      head_flat[ADDR_W-1-GROUP_W*i -: GROUP_W] = g;
    end
    addr_fin = ok_fin ? (head_flat | tail_fin) : '0;
  end

  // Step the parser on the popped item
  always_comb begin
    cur_next  = cur;
    dcnt_next = dcnt;
    ccnt_next = ccnt;
    gcnt_next = gcnt;
    gap_next  = gap;
    skip_next = skip;
    tail_next = tail;
    head_we   = 1'b0;
    head_idx  = gcnt[2:0];
    head_data = cur;
    res_fire  = 1'b0;
    res_ok    = 1'b0;
    res_ret   = 1'b0;
    res_addr  = '0;
    clear     = 1'b0;
    fail      = 1'b0;
    iscol     = head.item.is_colon && (ccnt < GAP_COLONS);
    c1        = ccnt;
    d1        = dcnt;
    cur1      = cur;
    gap1      = gap;
    if (pop) begin
      if (skip) begin
        // drop digits and colons, consume the terminator silently
        if (head.item.end_txt || (!head.item.is_hex && !head.item.is_colon)) begin
          skip_next = 1'b0;
        end
      end else if (head.item.end_txt || (!head.item.is_hex && !iscol)) begin
        // end of address text
        res_fire = 1'b1;
        res_ok   = ok_fin;
        res_ret  = !head.item.end_txt;
        res_addr = addr_fin;
        clear    = 1'b1;
      end else begin
        c1 = iscol ? ccnt + 2'd1 : ccnt;
        if (gcnt >= NGROUPS) begin
          fail = 1'b1;
        end else begin
          if (head.item.is_hex) begin
            if (dcnt >= MAX_DIGITS) begin
              fail = 1'b1;
            end else begin
              cur1 = {cur[GROUP_W-5:0], head.item.hex_val};
              c1   = 2'd0;
              d1   = dcnt + 3'd1;
            end
          end
          if (!fail && (c1 == GAP_COLONS)) begin
            if (has_gap) begin
              fail = 1'b1;
            end else begin
              gap1 = gcnt;
            end
          end
        end
        if (fail) begin
          res_fire  = 1'b1;
          clear     = 1'b1;
          skip_next = 1'b1;
        end else begin
          ccnt_next = c1;
          dcnt_next = d1;
          cur_next  = cur1;
          gap_next  = gap1;
          // close the group on a colon
          if ((c1 != 2'd0) && (d1 != 3'd0)) begin
            if (gap1 == NO_GAP) begin
              head_we   = 1'b1;
              head_data = cur1;
            end else begin
              tail_next = {tail[ADDR_W-GROUP_W-1:0], cur1};
            end
            gcnt_next = gcnt + 4'd1;
            cur_next  = '0;
            dcnt_next = 3'd0;
          end
        end
      end
    end
    if (clear) begin
      cur_next  = '0;
      dcnt_next = 3'd0;
      ccnt_next = 2'd0;
      gcnt_next = 4'd0;
      gap_next  = NO_GAP;
      tail_next = '0;
    end
  end

  // Hold groups written before the gap
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_grp[head_idx] <= head_data;
    end
  end

  // Update parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      dcnt <= 3'd0;
      ccnt <= 2'd0;
      gcnt <= 4'd0;
      gap  <= NO_GAP;
      skip <= 1'b0;
      tail <= '0;
    end else begin
      cur  <= cur_next;
      dcnt <= dcnt_next;
      ccnt <= ccnt_next;
      gcnt <= gcnt_next;
      gap  <= gap_next;
      skip <= skip_next;
      tail <= tail_next;
    end
  end

  // Output register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_ok   <= res_ok;
      out_ret  <= res_ret;
      out_addr <= res_addr;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_addr[ADDR_W/2-1:0], out_addr[ADDR_W-1:ADDR_W/2]};
  assign m_tuser  = {out_ret, out_ok};

endmodule

### tb/ipv6_address_text_parser_core_tb.sv
// Testbench for ipv6_address_text_parser_core: streams address text and checks each result.
// Depends on ipv6p_pkg and the parser RTL; it predicts every result with its own parser model.
module ipv6_address_text_parser_core_tb;
  import ipv6p_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        parse_ok;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic        char_returned;
  } addr_result_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;   // [7:0] character
  logic               s_tlast;   // end_of_text
  logic               m_tvalid;
  logic               m_tready;
  logic [ADDR_W-1:0]  m_tdata;   // [63:0] address_high, [127:64] address_low
  logic [1:0]         m_tuser;   // [0] parse_ok, [1] char_returned

  // Parser model state
  logic [15:0] grp_store [8];
  logic [15:0] cur_grp;
  logic [2:0]  n_digits;
  logic [1:0]  n_colons;
  logic [3:0]  n_groups;
  logic [3:0]  gap_at;
  logic        skipping;

  addr_result_t pending_results [$];
  int           parsed_chars;
  int           error_count;
  int           cycle_count;
  bit           idle_on;
  bit           hold_req;
  bit           hold_seen;
  int           hold_off;
  int           stall_left;

  ipv6_address_text_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hex value of a character, 16 when it is not a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b0, c[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      return t[4:0];
    end
    if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
      return t[4:0];
    end
    return 5'd16;
  endfunction

  task automatic clear_parse();
    cur_grp  = '0;
    n_digits = '0;
    n_colons = '0;
    n_groups = '0;
    gap_at   = NO_GAP;
  endtask

  // Expand the zero run, check the group count and queue the address
  task automatic close_address(input logic returned);
    logic [15:0]  g [8];
    logic [15:0]  e [8];
    int           n;
    int           zeros;
    addr_result_t r;
    for (int i = 0; i < 8; i++) g[i] = grp_store[i];
    n = int'(n_groups);
    if (n_digits > 0 && n < 8) begin
      g[n] = cur_grp;
      n++;
    end
    if (gap_at < NO_GAP && n <= 8) begin
      zeros = 8 - n;
      for (int i = 0; i < 8; i++) begin
        if (i < gap_at) e[i] = g[i];
        else if (i < gap_at + zeros) e[i] = '0;
        else e[i] = g[(i - zeros) & 7];
      end
      for (int i = 0; i < 8; i++) g[i] = e[i];
      n = 8;
    end
    r.parse_ok      = (n >= 8);
    r.address_high  = r.parse_ok ? {g[0], g[1], g[2], g[3]} : 64'd0;
    r.address_low   = r.parse_ok ? {g[4], g[5], g[6], g[7]} : 64'd0;
    r.char_returned = returned;
    pending_results.push_back(r);
    clear_parse();
  endtask

  task automatic fail_address();
    addr_result_t r;
    r = '0;
    pending_results.push_back(r);
    clear_parse();
    skipping = 1'b1;
  endtask

  // Advance the parser model by one accepted character
  task automatic parse_char(input logic [7:0] c, input logic eot);
    logic [4:0] d;
    logic       colon_ok;
    if (skipping) begin
      if (eot) begin
        skipping = 1'b0;
      end else begin
        d = hex_of(c);
        if (d == 5'd16 && c != CH_COLON) skipping = 1'b0;
      end
      return;
    end
    parsed_chars++;
    if (eot) begin
      close_address(1'b0);
      return;
    end
    d = hex_of(c);
    colon_ok = (d == 5'd16) && (c == CH_COLON) && (n_colons < GAP_COLONS);
    if (d == 5'd16 && !colon_ok) begin
      close_address(1'b1);
      return;
    end
    if (colon_ok) n_colons++;
    if (n_groups >= NGROUPS) begin
      fail_address();
      return;
    end
    if (d != 5'd16) begin
      if (n_digits >= MAX_DIGITS) begin
        fail_address();
        return;
      end
      cur_grp  = {cur_grp[11:0], d[3:0]};
      n_colons = '0;
      n_digits++;
    end
    if (n_colons == GAP_COLONS) begin
      if (gap_at < NO_GAP) begin
        fail_address();
        return;
      end
      gap_at = n_groups;
    end
    if (n_colons > 0 && n_digits > 0) begin
      grp_store[n_groups[2:0]] = cur_grp;
      n_groups++;
      cur_grp  = '0;
      n_digits = '0;
    end
  endtask

  // Offer one item, wait for its handshake, then predict
  task automatic send_item(input logic [7:0] c, input logic eot);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = eot;
    do @(posedge clk); while (!s_tready);
    parse_char(c, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return CH_ZERO + v;
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 8'd10;
  endfunction

  function automatic logic [7:0] rand_terminator();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_of(c) != 5'd16 || c == CH_COLON);
    return c;
  endfunction

  // Build one address, mostly well formed, sometimes broken, and send it
  task automatic send_random_address();
    logic [7:0] text_q [$];
    logic [7:0] c;
    int         n_grp;
    int         gap_pos;
    int         mangle;
    int         ndig;
    int         bad_grp;
    bit         use_gap;
    n_grp   = $urandom_range(0, 8);
    use_gap = ($urandom_range(0, 2) != 0);
    gap_pos = $urandom_range(0, n_grp);
    mangle  = $urandom_range(0, 11);
    if (mangle == 1) n_grp++;
    if (mangle == 4) use_gap = 1'b0;
    bad_grp = $urandom_range(0, (n_grp > 0) ? n_grp - 1 : 0);
    for (int g = 0; g < n_grp; g++) begin
      if (use_gap && g == gap_pos) begin
        text_q.push_back(CH_COLON);
        text_q.push_back(CH_COLON);
      end else if (g > 0) begin
        text_q.push_back(CH_COLON);
      end
      ndig = $urandom_range(1, 4);
      if (mangle == 0 && g == bad_grp) ndig = 5;
      repeat (ndig) text_q.push_back(rand_hex_char());
    end
    if (use_gap && gap_pos >= n_grp) begin
      text_q.push_back(CH_COLON);
      text_q.push_back(CH_COLON);
    end
    // Extra zero run at the tail, a second one when use_gap is set
    if (mangle == 2) begin
      text_q.push_back(CH_COLON);
      text_q.push_back(CH_COLON);
      text_q.push_back(rand_hex_char());
    end
    // Stray character anywhere in the text
    if (mangle == 3) begin
      c = 8'($urandom_range(0, 255));
      text_q.insert($urandom_range(0, text_q.size()), c);
    end
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    if ($urandom_range(0, 1)) begin
      c = 8'($urandom_range(0, 255));
      send_item(c, 1'b1);
    end else begin
      send_item(rand_terminator(), 1'b0);
    end
  endtask

  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 5)) begin
      c = 8'($urandom_range(0, 255));
      send_item(c, ($urandom_range(0, 7) == 0));
    end
  endtask

  // Hand-picked texts: extremes and each special case
  task automatic test_directed();
    send_item(8'h00, 1'b1);              // empty text, end marker
    send_item(8'h00, 1'b0);              // empty text, terminator
    send_text("::");                     // all-zero address
    send_item(8'hFF, 1'b1);
    send_text("fFfF::");                 // trailing zero run, top terminator code
    send_item(8'hFF, 1'b0);
    send_text(":::");                    // third colon ends the text
    send_text("12345");                  // fifth digit fails, rest skipped
    send_text("6");
    send_item(8'h20, 1'b1);
    send_text("1::2::");                 // second zero run
    send_text("x");
    send_text(":1");                     // leading single colon, too few groups
    send_item(8'h00, 1'b1);
    send_text("0:1:2:3:4:5:6:7:8");      // ninth group
    send_item(8'h00, 1'b1);
    send_text("FFFF:0:0:0:0:0:0:ffff");  // full address, no zero run
    send_item(8'h2F, 1'b0);
  endtask

  task automatic test_random(input int count);
    int target;
    target = parsed_chars + count;
    while (parsed_chars < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_address();
    end
  endtask

  // Hold the result side for a long stretch so the input stalls
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = ~hold_req;
    repeat (6) send_random_address();
    idle_on  = 1'b1;
  endtask

  // Result side ready: random stall bursts plus the long hold-off
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    hold_off   = 0;
    hold_seen  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_off  = HOLD_CYCLES;
      end
      if (hold_off > 0) begin
        m_tready = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expected address
  always @(posedge clk) begin : check_result
    addr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[0] !== want.parse_ok) begin
          $error("parse_ok: expected %0d, got %0d", want.parse_ok, m_tuser[0]);
          error_count++;
        end
        if (m_tdata[63:0] !== want.address_high) begin
          $error("address_high: expected %h, got %h", want.address_high, m_tdata[63:0]);
          error_count++;
        end
        if (m_tdata[127:64] !== want.address_low) begin
          $error("address_low: expected %h, got %h", want.address_low, m_tdata[127:64]);
          error_count++;
        end
        if (m_tuser[1] !== want.char_returned) begin
          $error("char_returned: expected %0d, got %0d", want.char_returned, m_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    parsed_chars = 0;
    error_count  = 0;
    cycle_count  = 0;
    skipping     = 1'b0;
    for (int i = 0; i < 8; i++) grp_store[i] = '0;
    clear_parse();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(850);
    test_backpressure();
    idle_on = 1'b0;
    test_random(150);

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
